FILE: rtl/rational_arith_reduce_macros.svh
// Assertion macros for the rational arithmetic block.
// Used by rational_arith_reduce.sv; expects signals clock and reset in scope.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// same-cycle implication
`define RAR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational_arith_reduce: same-cycle check failed");

// next-cycle implication
`define RAR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational_arith_reduce: next-cycle check failed");

`endif

FILE: rtl/rar_pkg.sv
// Shared types and constants for the rational arithmetic block.
// No dependencies; used by rar_if.sv and rational_arith_reduce.sv.
package rar_pkg;

   localparam int FIELD_W           = 32;
   localparam int RESULT_W          = 64;
   localparam int OPERAND_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_ZERO_DEN,
      STATUS_DIV_ZERO
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [FIELD_W-1:0]  first_num;
      logic signed [FIELD_W-1:0]  first_den;
      logic signed [FIELD_W-1:0]  second_num;
      logic signed [FIELD_W-1:0]  second_den;
   } req_payload_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] result_num;
      logic signed [RESULT_W-1:0] result_den;
      status_type                 status;
   } rsp_payload_type;

endpackage

FILE: rtl/rar_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on rar_pkg for the payload types.
interface rar_req_if;
   logic                      valid;
   logic                      ready;
   rar_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rar_rsp_if;
   logic                      valid;
   logic                      ready;
   rar_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/rational_arith_reduce.sv
// Sequence: capture, three products on the shared multiplier, one or two add steps (add and
// subtract only), halving of common twos, a binary GCD loop on the two magnitudes, 2*MAG_W
// divide steps and an output step (MAG_W = 2*OPERAND_WIDTH); on error the request goes
// straight from capture to output.
// One request at a time; ready only when idle.
// Reset: synchronous, active high; clears the sequencer and the response valid.
`include "rational_arith_reduce_macros.svh"

// Depends on rar_pkg and the channel interfaces in rar_if.sv.
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   rar_req_if.sink    req_ch,
   rar_rsp_if.source  rsp_ch
);

   localparam int W     = OPERAND_WIDTH;
   localparam int MAG_W = 2 * W;            // product and sum magnitudes
   localparam int AW    = MAG_W + 1;        // add/subtract operand width
   localparam int CNT_W = $clog2(MAG_W);

   // Sequence: capture, three products on one multiplier, signed-magnitude sum,
   // strip common twos, binary GCD on odd part, then two restoring divides.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADDS,
      ST_ADDR,
      ST_TWOS,
      ST_ODDU,
      ST_LOOP,
      ST_DIVN,
      ST_DIVD,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   rar_pkg::kind_type         kind_ff, kind_in;
   rar_pkg::status_type       status_ff, status_in;
   logic [W-1:0]              a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic [W-1:0]              c_mag_ff, c_mag_in, d_mag_ff, d_mag_in;
   logic                      a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic                      c_neg_ff, c_neg_in, d_neg_ff, d_neg_in;
   logic [MAG_W-1:0]          n_ff, n_in, dn_ff, dn_in, t_ff, t_in;
   logic                      n_neg_ff, n_neg_in, dn_neg_ff, dn_neg_in, t_neg_ff, t_neg_in;
   logic [MAG_W-1:0]          u_ff, u_in, v_ff, v_in, rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rar_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   // operand capture
   logic [W-1:0]              op_a, op_b, op_c, op_d;

   // shared multiplier
   logic [W-1:0]              mul_x, mul_y;
   logic [MAG_W-1:0]          mul_p;

   // shared add/subtract unit; ge is the no-borrow flag of a subtract
   logic [AW-1:0]             alu_x, alu_y;
   logic                      alu_sub;
   logic [AW:0]               alu_res;
   logic                      alu_ge;

   function automatic logic [rar_pkg::RESULT_W-1:0] to_field(
      input logic neg, input logic [MAG_W-1:0] mag);
      logic [rar_pkg::RESULT_W-1:0] m;
      m = rar_pkg::RESULT_W'(mag);
      if (m[rar_pkg::RESULT_W-1]) begin
         m = {1'b0, {(rar_pkg::RESULT_W-1){1'b1}}};   // saturate to 2^(RESULT_W-1)-1
      end
      return neg ? (~m + rar_pkg::RESULT_W'(1)) : m;
   endfunction

   assign mul_p   = MAG_W'(mul_x) * MAG_W'(mul_y);
   assign alu_res = alu_sub ? ({1'b0, alu_x} - {1'b0, alu_y})
                            : ({1'b0, alu_x} + {1'b0, alu_y});
   assign alu_ge  = !alu_res[AW];

   assign op_a = req_ch.payload.first_num[W-1:0];
   assign op_b = req_ch.payload.first_den[W-1:0];
   assign op_c = req_ch.payload.second_num[W-1:0];
   assign op_d = req_ch.payload.second_den[W-1:0];

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      a_mag_in     = a_mag_ff;
      b_mag_in     = b_mag_ff;
      c_mag_in     = c_mag_ff;
      d_mag_in     = d_mag_ff;
      a_neg_in     = a_neg_ff;
      b_neg_in     = b_neg_ff;
      c_neg_in     = c_neg_ff;
      d_neg_in     = d_neg_ff;
      n_in         = n_ff;
      dn_in        = dn_ff;
      t_in         = t_ff;
      n_neg_in     = n_neg_ff;
      dn_neg_in    = dn_neg_ff;
      t_neg_in     = t_neg_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      mul_x   = a_mag_ff;
      mul_y   = d_mag_ff;
      alu_x   = {1'b0, v_ff};
      alu_y   = {1'b0, u_ff};
      alu_sub = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in  = req_ch.payload.kind;
               a_neg_in = op_a[W-1];
               b_neg_in = op_b[W-1];
               c_neg_in = op_c[W-1];
               d_neg_in = op_d[W-1];
               // W-bit negate maps the most negative value onto 2^(W-1)
               a_mag_in = op_a[W-1] ? W'(-op_a) : op_a;
               b_mag_in = op_b[W-1] ? W'(-op_b) : op_b;
               c_mag_in = op_c[W-1] ? W'(-op_c) : op_c;
               d_mag_in = op_d[W-1] ? W'(-op_d) : op_d;
               cnt_in   = '0;
               if (op_b == '0 || op_d == '0) begin
                  status_in = rar_pkg::STATUS_ZERO_DEN;
               end else if (req_ch.payload.kind == rar_pkg::KIND_DIV && op_c == '0) begin
                  status_in = rar_pkg::STATUS_DIV_ZERO;
               end else begin
                  status_in = rar_pkg::STATUS_OK;
               end
               if (op_b == '0 || op_d == '0 ||
                   (req_ch.payload.kind == rar_pkg::KIND_DIV && op_c == '0)) begin
                  n_in      = '0;
                  dn_in     = '0;
                  n_neg_in  = 1'b0;
                  dn_neg_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  state_in  = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == '0) begin
               // a*c for multiply, a*d otherwise
               mul_x = a_mag_ff;
               mul_y = (kind_ff == rar_pkg::KIND_MUL) ? c_mag_ff : d_mag_ff;
               n_in  = mul_p;
               n_neg_in = a_neg_ff ^ ((kind_ff == rar_pkg::KIND_MUL) ? c_neg_ff : d_neg_ff);
            end else if (cnt_ff == CNT_W'(1)) begin
               // c*b, negated for subtract
               mul_x = c_mag_ff;
               mul_y = b_mag_ff;
               t_in  = mul_p;
               t_neg_in = c_neg_ff ^ b_neg_ff ^ (kind_ff == rar_pkg::KIND_SUB);
            end else begin
               // b*c for divide, b*d otherwise
               mul_x = b_mag_ff;
               mul_y = (kind_ff == rar_pkg::KIND_DIV) ? c_mag_ff : d_mag_ff;
               dn_in = mul_p;
               dn_neg_in = b_neg_ff ^ ((kind_ff == rar_pkg::KIND_DIV) ? c_neg_ff : d_neg_ff);
               if (kind_ff == rar_pkg::KIND_ADD || kind_ff == rar_pkg::KIND_SUB) begin
                  state_in = ST_ADDS;
               end else begin
                  state_in = ST_TWOS;
               end
            end
         end

         ST_ADDS: begin
            alu_x   = {1'b0, n_ff};
            alu_y   = {1'b0, t_ff};
            alu_sub = (n_neg_ff != t_neg_ff);
            if (n_neg_ff == t_neg_ff || alu_ge) begin
               n_in     = alu_res[MAG_W-1:0];
               state_in = ST_TWOS;
            end else begin
               state_in = ST_ADDR;
            end
         end

         ST_ADDR: begin
            // second term is larger: take t - n and its sign
            alu_x    = {1'b0, t_ff};
            alu_y    = {1'b0, n_ff};
            n_in     = alu_res[MAG_W-1:0];
            n_neg_in = t_neg_ff;
            state_in = ST_TWOS;
         end

         ST_TWOS: begin
            if (n_ff == '0) begin
               // gcd(0, den) is den itself
               dn_in    = MAG_W'(1);
               state_in = ST_FINISH;
            end else if (n_ff[0] || dn_ff[0]) begin
               u_in     = n_ff;
               v_in     = dn_ff;
               state_in = ST_ODDU;
            end else begin
               n_in  = n_ff >> 1;
               dn_in = dn_ff >> 1;
            end
         end

         ST_ODDU: begin
            if (u_ff[0]) begin
               state_in = ST_LOOP;
            end else begin
               u_in = u_ff >> 1;
            end
         end

         ST_LOOP: begin
            if (v_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_W'(MAG_W - 1);
               state_in = ST_DIVN;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (alu_ge) begin
               v_in = alu_res[MAG_W-1:0];
            end else begin
               u_in = v_ff;
               v_in = u_ff;
            end
         end

         ST_DIVN: begin
            alu_x = {rem_ff, n_ff[MAG_W-1]};
            alu_y = {1'b0, u_ff};
            rem_in = alu_ge ? alu_res[MAG_W-1:0] : {rem_ff[MAG_W-2:0], n_ff[MAG_W-1]};
            n_in   = {n_ff[MAG_W-2:0], alu_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_W'(MAG_W - 1);
               state_in = ST_DIVD;
            end
         end

         ST_DIVD: begin
            alu_x = {rem_ff, dn_ff[MAG_W-1]};
            alu_y = {1'b0, u_ff};
            rem_in = alu_ge ? alu_res[MAG_W-1:0] : {rem_ff[MAG_W-2:0], dn_ff[MAG_W-1]};
            dn_in  = {dn_ff[MAG_W-2:0], alu_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.result_num = $signed(to_field(n_neg_ff, n_ff));
               rsp_data_in.result_den = $signed(to_field(dn_neg_ff, dn_ff));
               rsp_data_in.status     = status_ff;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      status_ff   <= status_in;
      a_mag_ff    <= a_mag_in;
      b_mag_ff    <= b_mag_in;
      c_mag_ff    <= c_mag_in;
      d_mag_ff    <= d_mag_in;
      a_neg_ff    <= a_neg_in;
      b_neg_ff    <= b_neg_in;
      c_neg_ff    <= c_neg_in;
      d_neg_ff    <= d_neg_in;
      n_ff        <= n_in;
      dn_ff       <= dn_in;
      t_ff        <= t_in;
      n_neg_ff    <= n_neg_in;
      dn_neg_ff   <= dn_neg_in;
      t_neg_ff    <= t_neg_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // GCD loop only ever runs with an odd divisor candidate
   `RAR_ASSERT_IMP(a_loop_u_odd, state_ff == ST_LOOP, u_ff[0])
   // the reduction is exact: nothing left over after the last divide step
   `RAR_ASSERT_IMP(a_div_exact, $past(state_ff) == ST_DIVD && state_ff == ST_FINISH,
                   rem_ff == '0)
   // error responses carry zero fields
   `RAR_ASSERT_IMP(a_err_zero, rsp_ch.valid && rsp_ch.payload.status != rar_pkg::STATUS_OK,
                   rsp_ch.payload.result_num == '0 && rsp_ch.payload.result_den == '0)
   // zero numerator reduces straight to a unit denominator
   `RAR_ASSERT_NXT(a_zero_num, state_ff == ST_TWOS && n_ff == '0,
                   state_ff == ST_FINISH && dn_ff == MAG_W'(1))

endmodule
